// ----- hdl/piq_pkg.sv -----
// Shared types and constants for the point-in-quadrilateral filter.
`timescale 1ns / 1ps
package piq_pkg;

  localparam int COORD_W     = 16;
  localparam int STATUS_W    = 8;
  localparam int OUT_COUNT_W = 16;
  localparam int COUNT_BITS  = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int NUM_CORNERS = 4;
  localparam int CORNER_W    = $clog2(NUM_CORNERS);
  localparam int NUM_LINES   = 4;
  localparam int NUM_REGS    = 2 * NUM_CORNERS;

  // Line equation widths: a,b are corner differences, c is the difference of two
  // 16x16 cross products, the products are full 16x17 results, and the three-term sum needs two more bits.
  localparam int COEF_AB_W = COORD_W + 1;
  localparam int CROSS_W   = 2 * COORD_W;
  localparam int COEF_C_W  = CROSS_W + 1;
  localparam int PROD_W    = COEF_AB_W + COORD_W;
  localparam int VAL_W     = PROD_W + 2;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_W  = FIFO_PTR_W + 1;

  // Cycles the line coefficients need to follow a corner write.
  localparam int SETTLE_W      = 2;
  localparam int SETTLE_CYCLES = 2;

  typedef enum logic [2:0] {
    REG_C0_X = 3'd0,
    REG_C0_Y = 3'd1,
    REG_C1_X = 3'd2,
    REG_C1_Y = 3'd3,
    REG_C2_X = 3'd4,
    REG_C2_Y = 3'd5,
    REG_C3_X = 3'd6,
    REG_C3_Y = 3'd7
  } reg_idx_e;

  // Lines in order top, bottom, left, right; each runs from corner P to Q.
  localparam int LINE_TOP = 0;
  localparam int LINE_BOT = 1;
  localparam int LINE_LFT = 2;
  localparam int LINE_RGT = 3;
  localparam int LINE_P [NUM_LINES] = '{0, 1, 0, 3};
  localparam int LINE_Q [NUM_LINES] = '{3, 2, 1, 2};

  typedef struct packed {
    logic signed [COEF_AB_W-1:0] a;
    logic signed [COEF_AB_W-1:0] b;
    logic signed [COEF_C_W-1:0]  c;
  } piq_line_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                keep;
    logic                last;
  } piq_item_t;

endpackage

// ----- hdl/point_in_quad_filter.sv -----
// Point-in-quadrilateral filter: keeps tracked points inside four corner lines.
// Input to output valid: product stage, classify into the queue, count into
// the output register. Throughput: one point per cycle while input is not
// stalled; the four-entry queue bounds points in flight. A configuration
// write holds off input while the line coefficients update.
// Reset clears corners to 0, the kept count, the queue and all valid flags.
`timescale 1ns / 1ps
module point_in_quad_filter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [piq_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [piq_pkg::COORD_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [piq_pkg::COORD_W-1:0]   point_x_i,
  input  logic signed [piq_pkg::COORD_W-1:0]   point_y_i,
  input  logic [piq_pkg::STATUS_W-1:0]         status_in_i,
  input  logic                                 last_point_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [piq_pkg::STATUS_W-1:0]         status_out_o,
  output logic [piq_pkg::OUT_COUNT_W-1:0]      inside_count_o,
  output logic                                 last_out_o
);
  import piq_pkg::*;

  piq_line_t               coef [NUM_LINES];
  logic                    coef_busy;
  logic                    fifo_push;
  logic                    fifo_pop;
  logic                    fifo_empty;
  logic                    fifo_full;
  logic [FIFO_LVL_W-1:0]   fifo_level;
  piq_item_t               push_item;
  piq_item_t               pop_item;

  assign cfg_ready_o = 1'b1;

  piq_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef),
    .busy_o      (coef_busy)
  );

  piq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .status_in_i  (status_in_i),
    .last_point_i (last_point_i),
    .coef_i       (coef),
    .busy_i       (coef_busy),
    .q_level_i    (fifo_level),
    .push_o       (fifo_push),
    .item_o       (push_item)
  );

  piq_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (fifo_push),
    .wr_data_i (push_item),
    .pop_i     (fifo_pop),
    .rd_data_o (pop_item),
    .empty_o   (fifo_empty),
    .full_o    (fifo_full),
    .level_o   (fifo_level)
  );

  piq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (fifo_empty),
    .item_i         (pop_item),
    .pop_o          (fifo_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_out_o   (status_out_o),
    .inside_count_o (inside_count_o),
    .last_out_o     (last_out_o)
  );

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full)
    else $error("queue push while full");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty)
    else $error("queue pop while empty");

  a_cfg_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> in_stall_o)
    else $error("input taken while coefficients settle");

endmodule

// ----- hdl/piq_coef.sv -----
// Corner registers and the registered line coefficients derived from them.
`timescale 1ns / 1ps
module piq_coef (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [piq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [piq_pkg::COORD_W-1:0]      cfg_data_i,
  output piq_pkg::piq_line_t               coef_o [piq_pkg::NUM_LINES],
  output logic                             busy_o
);
  import piq_pkg::*;

  logic signed [COORD_W-1:0]   corner_x_q [NUM_CORNERS];
  logic signed [COORD_W-1:0]   corner_y_q [NUM_CORNERS];
  logic signed [COEF_AB_W-1:0] a_q [NUM_LINES];
  logic signed [COEF_AB_W-1:0] b_q [NUM_LINES];
  logic signed [CROSS_W-1:0]   m1_q [NUM_LINES];
  logic signed [CROSS_W-1:0]   m2_q [NUM_LINES];
  logic signed [COEF_C_W-1:0]  c_q [NUM_LINES];
  logic [SETTLE_W-1:0]         settle_q;
  logic                        wr_en;

  assign wr_en = cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        corner_x_q[i] <= '0;
        corner_y_q[i] <= '0;
      end
    end else if (wr_en) begin
      case (reg_idx_e'(cfg_index_i[2:0]))
        REG_C0_X: corner_x_q[0] <= cfg_data_i;
        REG_C0_Y: corner_y_q[0] <= cfg_data_i;
        REG_C1_X: corner_x_q[1] <= cfg_data_i;
        REG_C1_Y: corner_y_q[1] <= cfg_data_i;
        REG_C2_X: corner_x_q[2] <= cfg_data_i;
        REG_C2_Y: corner_y_q[2] <= cfg_data_i;
        REG_C3_X: corner_x_q[3] <= cfg_data_i;
        REG_C3_Y: corner_y_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Two stages: differences and cross products, then c = py*qx - qy*px.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LINES; l++) begin
        a_q[l]  <= '0;
        b_q[l]  <= '0;
        m1_q[l] <= '0;
        m2_q[l] <= '0;
        c_q[l]  <= '0;
      end
    end else begin
      for (int l = 0; l < NUM_LINES; l++) begin
        a_q[l]  <= COEF_AB_W'(corner_y_q[CORNER_W'(LINE_Q[l])])
                 - COEF_AB_W'(corner_y_q[CORNER_W'(LINE_P[l])]);
        b_q[l]  <= COEF_AB_W'(corner_x_q[CORNER_W'(LINE_P[l])])
                 - COEF_AB_W'(corner_x_q[CORNER_W'(LINE_Q[l])]);
        m1_q[l] <= CROSS_W'(corner_y_q[CORNER_W'(LINE_P[l])])
                 * CROSS_W'(corner_x_q[CORNER_W'(LINE_Q[l])]);
        m2_q[l] <= CROSS_W'(corner_y_q[CORNER_W'(LINE_Q[l])])
                 * CROSS_W'(corner_x_q[CORNER_W'(LINE_P[l])]);
        c_q[l]  <= COEF_C_W'(m1_q[l]) - COEF_C_W'(m2_q[l]);
      end
    end
  end

  // Hold off points until the coefficients reflect the latest write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= '0;
    end else if (cfg_valid_i) begin
      settle_q <= SETTLE_W'(SETTLE_CYCLES);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 1'b1;
    end
  end

  assign busy_o = (settle_q != '0);

  always_comb begin
    for (int l = 0; l < NUM_LINES; l++) begin
      coef_o[l].a = a_q[l];
      coef_o[l].b = b_q[l];
      coef_o[l].c = c_q[l];
    end
  end

endmodule

// ----- hdl/piq_front.sv -----
// Front end: accepts points, forms the line products and classifies each point.
`timescale 1ns / 1ps
module piq_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [piq_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [piq_pkg::COORD_W-1:0]  point_y_i,
  input  logic [piq_pkg::STATUS_W-1:0]        status_in_i,
  input  logic                                last_point_i,
  input  piq_pkg::piq_line_t                  coef_i [piq_pkg::NUM_LINES],
  input  logic                                busy_i,
  input  logic [piq_pkg::FIFO_LVL_W-1:0]      q_level_i,
  output logic                                push_o,
  output piq_pkg::piq_item_t                  item_o
);
  import piq_pkg::*;

  logic                       f1_valid_q;
  logic signed [PROD_W-1:0]   ax_q [NUM_LINES];
  logic signed [PROD_W-1:0]   by_q [NUM_LINES];
  logic [STATUS_W-1:0]        status_q;
  logic                       last_q;
  logic [FIFO_LVL_W-1:0]      in_flight;
  logic                       accept;
  logic signed [VAL_W-1:0]    val [NUM_LINES];
  logic [NUM_LINES-1:0]       neg;
  logic [NUM_LINES-1:0]       zero;
  logic                       in_quad;
  logic                       tested;

  // Queue slots are reserved for the point in the product stage too.
  assign in_flight  = q_level_i + FIFO_LVL_W'(f1_valid_q);
  assign in_stall_o = busy_i || (in_flight >= FIFO_LVL_W'(FIFO_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int l = 0; l < NUM_LINES; l++) begin
        ax_q[l] <= PROD_W'(coef_i[l].a) * PROD_W'(point_x_i);
        by_q[l] <= PROD_W'(coef_i[l].b) * PROD_W'(point_y_i);
      end
      status_q <= status_in_i;
      last_q   <= last_point_i;
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LINES; l++) begin
      val[l]  = VAL_W'(ax_q[l]) + VAL_W'(by_q[l]) + VAL_W'(coef_i[l].c);
      neg[l]  = val[l][VAL_W-1];
      zero[l] = (val[l] == '0);
    end
    // A pair passes unless both values are nonzero with the same sign.
    in_quad = (zero[LINE_TOP] || zero[LINE_BOT] || (neg[LINE_TOP] != neg[LINE_BOT])) &&
              (zero[LINE_LFT] || zero[LINE_RGT] || (neg[LINE_LFT] != neg[LINE_RGT]));
    tested = (status_q != '0);
    item_o.status = (!tested || in_quad) ? status_q : '0;
    item_o.keep   = tested && in_quad;
    item_o.last   = last_q;
  end

  assign push_o = f1_valid_q;

endmodule

// ----- hdl/piq_fifo.sv -----
// Short queue between the classifier and the counting back end.
`timescale 1ns / 1ps
module piq_fifo (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  piq_pkg::piq_item_t                 wr_data_i,
  input  logic                               pop_i,
  output piq_pkg::piq_item_t                 rd_data_o,
  output logic                               empty_o,
  output logic                               full_o,
  output logic [piq_pkg::FIFO_LVL_W-1:0]     level_o
);
  import piq_pkg::*;

  piq_item_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q;
  logic [FIFO_PTR_W-1:0]   rd_ptr_q;
  logic [FIFO_LVL_W-1:0]   level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + 1'b1;
      end else if (pop_i && !push_i) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];
  assign empty_o   = (level_q == '0);
  assign full_o    = (level_q == FIFO_LVL_W'(FIFO_DEPTH));
  assign level_o   = level_q;

endmodule

// ----- hdl/piq_back.sv -----
// Back end: running kept count and the output register.
`timescale 1ns / 1ps
module piq_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 empty_i,
  input  piq_pkg::piq_item_t                   item_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [piq_pkg::STATUS_W-1:0]         status_out_o,
  output logic [piq_pkg::OUT_COUNT_W-1:0]      inside_count_o,
  output logic                                 last_out_o
);
  import piq_pkg::*;

  logic [COUNT_BITS-1:0]   count_q;
  logic [COUNT_BITS-1:0]   count_d;
  logic                    out_valid_q;
  logic [STATUS_W-1:0]     status_q;
  logic [OUT_COUNT_W-1:0]  inside_count_q;
  logic                    last_q;

  // Advance when the output register is free or being taken this cycle.
  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    count_d = count_q;
    if (item_i.keep && (count_q != '1)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        count_q     <= item_i.last ? '0 : count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q       <= item_i.status;
      inside_count_q <= OUT_COUNT_W'(count_d);
      last_q         <= item_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_out_o   = status_q;
  assign inside_count_o = inside_count_q;
  assign last_out_o     = last_q;

endmodule
